@@ rtl/mcwc_pkg.sv @@
// Shared constants, register codes and types for the multichannel window comparator.
package mcwc_pkg;

	localparam int LANES           = 4;
	localparam int OHM_W           = 16;
	localparam int CHANNELS_DEF    = 4;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMITS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMITS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_DELAYS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_DELAYS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK = 3'd4;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] low_limits;
		logic [CFG_DATA_W-1:0] high_limits;
		logic [CFG_DATA_W-1:0] low_delays;
		logic [CFG_DATA_W-1:0] high_delays;
		logic [LANES-1:0]      invert_mask;
	} cfg_t;

	typedef struct packed {
		logic [OHM_W-1:0] low_limit;
		logic [OHM_W-1:0] high_limit;
		logic [OHM_W-1:0] low_delay;
		logic [OHM_W-1:0] high_delay;
		logic             invert;
	} chan_cfg_t;

endpackage

@@ rtl/mcwc_cfg_regs.sv @@
// Configuration register bank: limits, delays and polarity mask.
module mcwc_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [mcwc_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [mcwc_pkg::CFG_DATA_W-1:0]   wr_data,
	output mcwc_pkg::cfg_t                    cfg
);

	mcwc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				mcwc_pkg::REG_LOW_LIMITS:  cfg_q.low_limits  <= wr_data;
				mcwc_pkg::REG_HIGH_LIMITS: cfg_q.high_limits <= wr_data;
				mcwc_pkg::REG_LOW_DELAYS:  cfg_q.low_delays  <= wr_data;
				mcwc_pkg::REG_HIGH_DELAYS: cfg_q.high_delays <= wr_data;
				mcwc_pkg::REG_INVERT_MASK: cfg_q.invert_mask <= wr_data[mcwc_pkg::LANES-1:0];
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/mcwc_channel.sv @@
// One comparator lane: below-low and above-high qualification counters.
module mcwc_channel (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [mcwc_pkg::OHM_W-1:0]    sample,
	input  mcwc_pkg::chan_cfg_t           cfg,
	input  logic                          cur_bit,
	output logic                          nxt_bit
);

	logic [mcwc_pkg::OHM_W-1:0] below_cnt_q, above_cnt_q;
	logic [mcwc_pkg::OHM_W-1:0] below_cnt_nxt, above_cnt_nxt;
	logic                       is_below, is_above;
	logic                       bit_mid;

	assign is_below = (sample < cfg.low_limit);
	assign is_above = (sample > cfg.high_limit);

	always_comb begin
		below_cnt_nxt = below_cnt_q;
		above_cnt_nxt = above_cnt_q;
		bit_mid       = cur_bit;
		nxt_bit       = cur_bit;

		// low check first
		if (is_below) begin
			if (below_cnt_q != '0) begin
				below_cnt_nxt = below_cnt_q - 1'b1;
			end else begin
				bit_mid = cfg.invert;
			end
		end else begin
			below_cnt_nxt = cfg.low_delay;
		end

		// high check last, so it wins
		nxt_bit = bit_mid;
		if (is_above) begin
			if (above_cnt_q != '0) begin
				above_cnt_nxt = above_cnt_q - 1'b1;
			end else begin
				nxt_bit = ~cfg.invert;
			end
		end else begin
			above_cnt_nxt = cfg.high_delay;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			below_cnt_q <= '0;
			above_cnt_q <= '0;
		end else if (en) begin
			below_cnt_q <= below_cnt_nxt;
			above_cnt_q <= above_cnt_nxt;
		end
	end

endmodule

@@ rtl/multichannel_window_comparator.sv @@
// Top level of the multichannel time-qualified window comparator.
// Each input beat carries one resistance sample per channel plus start/stop
// requests; each input beat yields exactly one output beat with the per-channel
// alarm bits and the run flag after that beat. Start sets the run flag, stop
// clears it, stop wins when both are set. While running, a channel's output bit
// goes to 0 (1 if inverted) once its sample has stayed below the low limit for
// low_delay further beats, and to 1 (0 if inverted) once above the high limit
// for high_delay further beats; the high check decides if both fire. While
// stopped, counters and alarm bits hold. Samples saturate to SAMPLE_BITS bits
// before comparison. Throughput is one beat per clock while the output register
// is not held: the datapath is an input register, one level of compare/decrement
// logic per lane, and an output register that takes each beat once it is free;
// s_axis_tready drops only while the output register is held by m_axis_tready.
// Configuration writes are accepted every cycle and should be issued only while
// no beat is in flight.
module multichannel_window_comparator #(
	parameter int CHANNELS    = mcwc_pkg::CHANNELS_DEF,    // 1..4
	parameter int SAMPLE_BITS = mcwc_pkg::SAMPLE_BITS_DEF  // 8..16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	// input stream
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [15:0] ohm_ch0, [31:16] ohm_ch1, [47:32] ohm_ch2, [63:48] ohm_ch3,
	// [64] start_req, [65] stop_req, [71:66] zero
	input  logic [mcwc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,

	// result stream
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [3:0] alarm_bits, [4] is_running, [7:5] zero
	output logic [mcwc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,

	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mcwc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mcwc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int LANES = mcwc_pkg::LANES;
	localparam int OHM_W = mcwc_pkg::OHM_W;
	localparam logic [OHM_W-1:0] SAMPLE_MAX = OHM_W'((32'd1 << SAMPLE_BITS) - 32'd1);

	// ---------------- configuration ----------------
	mcwc_pkg::cfg_t cfg;

	assign cfg_ready = 1'b1;

	mcwc_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// ---------------- handshake / flow ----------------
	logic             valid_s1;
	logic             m_valid_q;
	logic             out_free;
	logic             adv_s1;
	logic             in_take;

	assign out_free      = ~m_valid_q | m_axis_tready;
	assign adv_s1        = valid_s1 & out_free;
	assign s_axis_tready = ~valid_s1 | out_free;
	assign in_take       = s_axis_tvalid & s_axis_tready;

	// ---------------- input register ----------------
	logic [OHM_W-1:0] ohm_s1 [LANES];
	logic             start_s1, stop_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			for (int i = 0; i < LANES; i++) begin
				ohm_s1[i] <= s_axis_tdata[i*OHM_W +: OHM_W];
			end
			start_s1 <= s_axis_tdata[LANES*OHM_W];
			stop_s1  <= s_axis_tdata[LANES*OHM_W+1];
		end
	end

	// ---------------- run flag and lane update ----------------
	logic             run_q;
	logic             run_nxt;
	logic [LANES-1:0] out_bits_q;
	logic [LANES-1:0] out_bits_nxt;
	logic [LANES-1:0] lane_bit;
	logic             lane_en;

	// stop applied after start
	assign run_nxt = stop_s1 ? 1'b0 : (start_s1 ? 1'b1 : run_q);
	assign lane_en = adv_s1 & run_nxt;

	for (genvar ch = 0; ch < LANES; ch++) begin : g_lane
		if (ch < CHANNELS) begin : g_used
			logic [OHM_W-1:0]    sample_sat;
			mcwc_pkg::chan_cfg_t ch_cfg;

			assign sample_sat = (ohm_s1[ch] > SAMPLE_MAX) ? SAMPLE_MAX : ohm_s1[ch];

			assign ch_cfg.low_limit  = cfg.low_limits [ch*OHM_W +: OHM_W];
			assign ch_cfg.high_limit = cfg.high_limits[ch*OHM_W +: OHM_W];
			assign ch_cfg.low_delay  = cfg.low_delays [ch*OHM_W +: OHM_W];
			assign ch_cfg.high_delay = cfg.high_delays[ch*OHM_W +: OHM_W];
			assign ch_cfg.invert     = cfg.invert_mask[ch];

			mcwc_channel u_channel (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (lane_en),
				.sample  (sample_sat),
				.cfg     (ch_cfg),
				.cur_bit (out_bits_q[ch]),
				.nxt_bit (lane_bit[ch])
			);

			assign out_bits_nxt[ch] = run_nxt ? lane_bit[ch] : out_bits_q[ch];
		end else begin : g_unused
			// channel not built: bit stays low
			assign lane_bit[ch]     = 1'b0;
			assign out_bits_nxt[ch] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= 1'b0;
			out_bits_q <= '0;
		end else if (adv_s1) begin
			run_q      <= run_nxt;
			out_bits_q <= out_bits_nxt;
		end
	end

	// ---------------- result register ----------------
	logic [mcwc_pkg::OUT_TDATA_W-1:0] res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= {{(mcwc_pkg::OUT_TDATA_W-LANES-1){1'b0}}, run_nxt, out_bits_nxt};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = res_q;

	// ---------------- assertions ----------------
	// stopped beats leave the alarm bits untouched
	a_hold_when_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && !run_nxt |=> $stable(out_bits_q))
		else $error("alarm bits changed while stopped");

	// stop request always leaves the block stopped
	a_stop_wins: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && stop_s1 |=> !run_q)
		else $error("run flag set after stop request");

	// channels not built never raise a bit
	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_bits_q >> CHANNELS) == '0)
		else $error("alarm bit set on unused channel");

	// every processed beat shows up in the result register
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> m_axis_tvalid && (m_axis_tdata[LANES] == run_q))
		else $error("processed beat missing from result register");

	// empty input stage never back-pressures
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stalled with empty stage");

endmodule
